// ===== rtl/sts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, constants and the keyword table of the SQL token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int KW_MAX_LEN_DEF = 9;
  localparam int POS_WIDTH_DEF  = 16;
  localparam int KW_ENTRIES     = 57;
  localparam int KW_CHARS       = 9;
  localparam int Q_DEPTH        = 8;

  // result kinds
  localparam logic [1:0] RK_VALUE = 2'd0;
  localparam logic [1:0] RK_TOKEN = 2'd1;
  localparam logic [1:0] RK_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_CHAR     = 2'd1;
  localparam logic [1:0] ERR_UNCLOSED = 2'd2;

  // token types
  localparam logic [6:0] TT_IDENT  = 7'd0;
  localparam logic [6:0] TT_INT    = 7'd1;
  localparam logic [6:0] TT_FLOAT  = 7'd2;
  localparam logic [6:0] TT_STRING = 7'd3;
  localparam logic [6:0] TT_EQ     = 7'd4;
  localparam logic [6:0] TT_NE     = 7'd5;
  localparam logic [6:0] TT_LT     = 7'd6;
  localparam logic [6:0] TT_LE     = 7'd7;
  localparam logic [6:0] TT_GT     = 7'd8;
  localparam logic [6:0] TT_GE     = 7'd9;
  localparam logic [6:0] TT_LPAREN = 7'd10;
  localparam logic [6:0] TT_RPAREN = 7'd11;
  localparam logic [6:0] TT_COMMA  = 7'd12;
  localparam logic [6:0] TT_SEMI   = 7'd13;
  localparam logic [6:0] TT_STAR   = 7'd14;
  localparam logic [6:0] TT_END    = 7'd15;

  typedef enum logic [3:0] {
    S_IDLE, S_NUM, S_IDENT, S_STR, S_ESC, S_LT, S_GT,
    S_BANG, S_DASH, S_COMMENT, S_ERROR
  } mode_t;

  // one result without its position
  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] ttype;
    logic [7:0] val;
    logic [1:0] err;
    logic       last;
  } res_info_t;

  typedef struct packed {
    logic [3:0] txt_len;
    logic [6:0] code;
    logic [8*KW_CHARS-1:0] txt;
  } kw_t;

  function automatic kw_t kw_entry(input logic [5:0] k);
    kw_t e;
    case (k)
      6'd0:  e = '{4'd6, 7'd16, 72'("SELECT")};
      6'd1:  e = '{4'd4, 7'd17, 72'("FROM")};
      6'd2:  e = '{4'd5, 7'd18, 72'("WHERE")};
      6'd3:  e = '{4'd6, 7'd19, 72'("INSERT")};
      6'd4:  e = '{4'd4, 7'd20, 72'("INTO")};
      6'd5:  e = '{4'd6, 7'd21, 72'("VALUES")};
      6'd6:  e = '{4'd6, 7'd22, 72'("UPDATE")};
      6'd7:  e = '{4'd3, 7'd23, 72'("SET")};
      6'd8:  e = '{4'd6, 7'd24, 72'("DELETE")};
      6'd9:  e = '{4'd6, 7'd25, 72'("CREATE")};
      6'd10: e = '{4'd4, 7'd26, 72'("DROP")};
      6'd11: e = '{4'd5, 7'd27, 72'("TABLE")};
      6'd12: e = '{4'd8, 7'd28, 72'("DATABASE")};
      6'd13: e = '{4'd3, 7'd29, 72'("USE")};
      6'd14: e = '{4'd3, 7'd30, 72'("INT")};
      6'd15: e = '{4'd7, 7'd30, 72'("INTEGER")};
      6'd16: e = '{4'd5, 7'd31, 72'("FLOAT")};
      6'd17: e = '{4'd4, 7'd32, 72'("BOOL")};
      6'd18: e = '{4'd7, 7'd32, 72'("BOOLEAN")};
      6'd19: e = '{4'd4, 7'd33, 72'("TEXT")};
      6'd20: e = '{4'd7, 7'd34, 72'("VARCHAR")};
      6'd21: e = '{4'd3, 7'd35, 72'("AND")};
      6'd22: e = '{4'd2, 7'd36, 72'("OR")};
      6'd23: e = '{4'd3, 7'd37, 72'("NOT")};
      6'd24: e = '{4'd4, 7'd38, 72'("TRUE")};
      6'd25: e = '{4'd5, 7'd39, 72'("FALSE")};
      6'd26: e = '{4'd4, 7'd40, 72'("NULL")};
      6'd27: e = '{4'd5, 7'd41, 72'("ORDER")};
      6'd28: e = '{4'd2, 7'd42, 72'("BY")};
      6'd29: e = '{4'd3, 7'd43, 72'("ASC")};
      6'd30: e = '{4'd4, 7'd44, 72'("DESC")};
      6'd31: e = '{4'd5, 7'd45, 72'("LIMIT")};
      6'd32: e = '{4'd6, 7'd46, 72'("OFFSET")};
      6'd33: e = '{4'd5, 7'd47, 72'("GROUP")};
      6'd34: e = '{4'd6, 7'd48, 72'("HAVING")};
      6'd35: e = '{4'd5, 7'd49, 72'("COUNT")};
      6'd36: e = '{4'd3, 7'd50, 72'("SUM")};
      6'd37: e = '{4'd3, 7'd51, 72'("AVG")};
      6'd38: e = '{4'd3, 7'd52, 72'("MIN")};
      6'd39: e = '{4'd3, 7'd53, 72'("MAX")};
      6'd40: e = '{4'd4, 7'd54, 72'("JOIN")};
      6'd41: e = '{4'd5, 7'd55, 72'("INNER")};
      6'd42: e = '{4'd2, 7'd56, 72'("ON")};
      6'd43: e = '{4'd4, 7'd57, 72'("USER")};
      6'd44: e = '{4'd8, 7'd58, 72'("PASSWORD")};
      6'd45: e = '{4'd4, 7'd59, 72'("WITH")};
      6'd46: e = '{4'd4, 7'd60, 72'("ROLE")};
      6'd47: e = '{4'd5, 7'd61, 72'("GRANT")};
      6'd48: e = '{4'd6, 7'd62, 72'("REVOKE")};
      6'd49: e = '{4'd2, 7'd63, 72'("TO")};
      6'd50: e = '{4'd3, 7'd64, 72'("ALL")};
      6'd51: e = '{4'd4, 7'd65, 72'("SHOW")};
      6'd52: e = '{4'd5, 7'd66, 72'("USERS")};
      6'd53: e = '{4'd4, 7'd67, 72'("AUTH")};
      6'd54: e = '{4'd8, 7'd68, 72'("READONLY")};
      6'd55: e = '{4'd9, 7'd69, 72'("READWRITE")};
      6'd56: e = '{4'd5, 7'd70, 72'("ADMIN")};
      default: e = '{4'd15, TT_IDENT, 72'd0};
    endcase
    return e;
  endfunction

  // Parallel match of the upper-cased word against every keyword; first hit wins.
  function automatic logic [6:0] kw_lookup(input logic [7:0] w [KW_CHARS],
                                           input logic [4:0] len);
    kw_t        e;
    logic       ok;
    logic [6:0] code;
    int         pos;
    code = TT_IDENT;
    for (int k = KW_ENTRIES - 1; k >= 0; k--) begin
      e  = kw_entry(6'(k));
      ok = (len == {1'b0, e.txt_len});
      for (int i = 0; i < KW_CHARS; i++) begin
        pos = 8 * (int'(e.txt_len) - 1 - i);
        if (i < int'(e.txt_len) && w[i] != e.txt[pos +: 8]) ok = 1'b0;
      end
      if (ok) code = e.code;
    end
    return code;
  endfunction

endpackage

// ===== rtl/sts_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_if
// Source text channel and token result channel of the SQL token scanner.
// ----------------------------------------------------------------------------
interface sts_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_source;

  modport source (output valid, char_byte, end_of_source, input ready);
  modport sink   (input valid, char_byte, end_of_source, output ready);
endinterface

interface sts_token_if #(parameter int PW = 16);
  logic          valid;
  logic          ready;
  logic [1:0]    result_kind;
  logic [6:0]    token_type;
  logic [7:0]    value_byte;
  logic [PW-1:0] start_line;
  logic [PW-1:0] start_col;
  logic [1:0]    error_code;
  logic          last_of_run;

  modport source (output valid, result_kind, token_type, value_byte, start_line,
                  start_col, error_code, last_of_run, input ready);
  modport sink   (input valid, result_kind, token_type, value_byte, start_line,
                  start_col, error_code, last_of_run, output ready);
endinterface

// ===== rtl/sql_token_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sql_token_scanner
// Streaming SQL tokenizer: one byte a cycle while its result queue has room.
// ----------------------------------------------------------------------------
// Output: the results of an accepted byte are registered into the queue.
// Throughput: one byte a cycle while the eight-entry result queue holds at
// most five results; each result leaves at one a cycle, so bytes causing
// several results are paced by the result port.
// Reset: synchronous; scanner returns to idle at line 1, column 1, queue empty.
// ----------------------------------------------------------------------------
module sql_token_scanner #(
  parameter int KEYWORD_MAX_LEN = sts_pkg::KW_MAX_LEN_DEF,
  parameter int POSITION_WIDTH  = sts_pkg::POS_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sts_text_if.sink    text,
  sts_token_if.source tokens
);
  import sts_pkg::*;

  logic                      accept, room;
  logic [1:0]                push_cnt;
  res_info_t                 info [3];
  logic [POSITION_WIDTH-1:0] line [3];
  logic [POSITION_WIDTH-1:0] col [3];
  mode_t                     scan_mode;
  logic [$clog2(Q_DEPTH+1)-1:0] fill;

  assign text.ready = room;
  assign accept     = text.valid && room;

  sts_front #(
    .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
    .POSITION_WIDTH  (POSITION_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .char_byte     (text.char_byte),
    .end_of_source (text.end_of_source),
    .push_cnt      (push_cnt),
    .info          (info),
    .line          (line),
    .col           (col),
    .scan_mode     (scan_mode)
  );

  sts_queue #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (push_cnt),
    .info     (info),
    .line     (line),
    .col      (col),
    .room     (room),
    .fill     (fill),
    .tokens   (tokens)
  );

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= ($clog2(Q_DEPTH+1))'(Q_DEPTH))
    else $error("result queue overfilled");

  a_eos_idle: assert property (@(posedge clk) disable iff (rst)
    accept && text.end_of_source |=> scan_mode == S_IDLE)
    else $error("scanner not idle after end of source");

  a_push_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |-> push_cnt == 2'd0)
    else $error("results pushed without an accepted byte");

endmodule

// ===== rtl/sts_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_front
// Scanner front end: classifies each source byte and forms up to three
// results for it in the same cycle.
// ----------------------------------------------------------------------------
module sts_front #(
  parameter int KEYWORD_MAX_LEN = 9,
  parameter int POSITION_WIDTH  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [7:0]                char_byte,
  input  logic                      end_of_source,
  output logic [1:0]                push_cnt,
  output sts_pkg::res_info_t        info [3],
  output logic [POSITION_WIDTH-1:0] line [3],
  output logic [POSITION_WIDTH-1:0] col [3],
  output sts_pkg::mode_t            scan_mode
);
  import sts_pkg::*;

  localparam int LW = $clog2(KEYWORD_MAX_LEN + 2);
  localparam int IW = $clog2(KEYWORD_MAX_LEN);
  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;
  localparam logic [LW-1:0] LEN_MAX  = LW'(KEYWORD_MAX_LEN);
  localparam logic [LW-1:0] LEN_OVER = LW'(KEYWORD_MAX_LEN + 1);

  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_LOW_N  = 8'h6e;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  mode_t                     mode, mode_next;
  logic [POSITION_WIDTH-1:0] line_count, line_count_next;
  logic [POSITION_WIDTH-1:0] col_count, col_count_next;
  logic [POSITION_WIDTH-1:0] token_line, token_line_next;
  logic [POSITION_WIDTH-1:0] token_col, token_col_next;
  logic [7:0]                wbuf [KEYWORD_MAX_LEN];
  logic [7:0]                wbuf_next [KEYWORD_MAX_LEN];
  logic [LW-1:0]             wlen, wlen_next;
  logic [LW-1:0]             wlen_tok;
  logic                      seen_dot, seen_dot_next;

  function automatic res_info_t mk(input logic [1:0] kind, input logic [6:0] tt,
                                   input logic [7:0] v, input logic [1:0] e);
    res_info_t r;
    r.kind  = kind;
    r.ttype = tt;
    r.val   = v;
    r.err   = e;
    r.last  = 1'b0;
    return r;
  endfunction

  // byte classes
  logic       is_digit, is_alpha, is_space, is_word;
  logic [7:0] upper;
  always_comb begin
    is_digit = (char_byte inside {[8'h30:8'h39]});
    is_alpha = (char_byte inside {[8'h41:8'h5a], [8'h61:8'h7a]});
    is_space = (char_byte == CH_SPACE) || (char_byte inside {[CH_TAB:8'h0d]});
    is_word  = is_alpha || is_digit || (char_byte == CH_UNDER);
    upper    = (char_byte inside {[8'h61:8'h7a]}) ? (char_byte - 8'h20) : char_byte;
  end

  // byte seen between tokens
  logic      id_emit, id_num, id_ident;
  res_info_t id_res;
  mode_t     id_mode;
  always_comb begin
    id_emit  = 1'b1;
    id_num   = 1'b0;
    id_ident = 1'b0;
    id_mode  = S_IDLE;
    id_res   = mk(RK_TOKEN, TT_IDENT, 8'd0, ERR_NONE);
    if (is_space) begin
      id_emit = 1'b0;
    end else if (is_digit) begin
      id_num  = 1'b1;
      id_mode = S_NUM;
      id_res  = mk(RK_VALUE, TT_INT, char_byte, ERR_NONE);
    end else if (is_alpha || char_byte == CH_UNDER) begin
      id_ident = 1'b1;
      id_mode  = S_IDENT;
      id_res   = mk(RK_VALUE, TT_IDENT, char_byte, ERR_NONE);
    end else begin
      case (char_byte)
        CH_QUOTE:  begin id_emit = 1'b0; id_mode = S_STR;  end
        CH_LT:     begin id_emit = 1'b0; id_mode = S_LT;   end
        CH_GT:     begin id_emit = 1'b0; id_mode = S_GT;   end
        CH_BANG:   begin id_emit = 1'b0; id_mode = S_BANG; end
        CH_DASH:   begin id_emit = 1'b0; id_mode = S_DASH; end
        CH_EQ:     id_res = mk(RK_TOKEN, TT_EQ, 8'd0, ERR_NONE);
        CH_LPAREN: id_res = mk(RK_TOKEN, TT_LPAREN, 8'd0, ERR_NONE);
        CH_RPAREN: id_res = mk(RK_TOKEN, TT_RPAREN, 8'd0, ERR_NONE);
        CH_COMMA:  id_res = mk(RK_TOKEN, TT_COMMA, 8'd0, ERR_NONE);
        CH_SEMI:   id_res = mk(RK_TOKEN, TT_SEMI, 8'd0, ERR_NONE);
        CH_STAR:   id_res = mk(RK_TOKEN, TT_STAR, 8'd0, ERR_NONE);
        default: begin
          id_res  = mk(RK_ERROR, TT_IDENT, 8'd0, ERR_CHAR);
          id_mode = S_ERROR;
        end
      endcase
    end
  end

  // keyword lookups: held word, and word including this byte (for the flush)
  logic [7:0] kw_cur [KW_CHARS];
  logic [7:0] kw_nxt [KW_CHARS];
  logic [6:0] type_cur, type_nxt;
  always_comb begin
    for (int i = 0; i < KW_CHARS; i++) begin
      kw_cur[i] = wbuf[i];
      kw_nxt[i] = wbuf_next[i];
    end
    type_cur = kw_lookup(kw_cur, 5'(wlen));
    type_nxt = kw_lookup(kw_nxt, 5'(wlen_tok));
  end

  // per-byte scan step
  res_info_t                 r_info [4];
  logic [POSITION_WIDTH-1:0] r_line [4];
  logic [POSITION_WIDTH-1:0] r_col [4];
  logic [2:0]                n;
  logic                      do_idle, fresh, err_end;
  logic [6:0]                ft;
  logic [7:0]                fv;
  always_comb begin
    mode_next       = mode;
    token_line_next = token_line;
    token_col_next  = token_col;
    seen_dot_next   = seen_dot;
    wlen_next       = wlen;
    wbuf_next       = wbuf;
    line_count_next = line_count;
    col_count_next  = col_count;
    n               = 3'd0;
    do_idle         = 1'b0;
    fresh           = 1'b0;
    err_end         = 1'b0;
    ft              = TT_IDENT;
    fv              = 8'd0;
    for (int k = 0; k < 4; k++) begin
      r_info[k] = mk(RK_VALUE, TT_IDENT, 8'd0, ERR_NONE);
      r_line[k] = token_line;
      r_col[k]  = token_col;
    end

    case (mode)
      S_NUM: begin
        if (is_digit) begin
          r_info[n[1:0]] = mk(RK_VALUE, seen_dot ? TT_FLOAT : TT_INT, char_byte, ERR_NONE);
          n = n + 3'd1;
        end else if (char_byte == CH_DOT && !seen_dot) begin
          seen_dot_next  = 1'b1;
          r_info[n[1:0]] = mk(RK_VALUE, TT_FLOAT, char_byte, ERR_NONE);
          n = n + 3'd1;
        end else begin
          r_info[n[1:0]] = mk(RK_TOKEN, seen_dot ? TT_FLOAT : TT_INT, 8'd0, ERR_NONE);
          n = n + 3'd1;
          do_idle = 1'b1;
        end
      end
      S_IDENT: begin
        if (is_word) begin
          if (wlen < LEN_MAX) begin
            wbuf_next[wlen[IW-1:0]] = upper;
            wlen_next = wlen + LW'(1);
          end else begin
            wlen_next = LEN_OVER;
          end
          r_info[n[1:0]] = mk(RK_VALUE, TT_IDENT, char_byte, ERR_NONE);
          n = n + 3'd1;
        end else begin
          r_info[n[1:0]] = mk(RK_TOKEN, type_cur, 8'd0, ERR_NONE);
          n = n + 3'd1;
          do_idle = 1'b1;
        end
      end
      S_STR: begin
        if (char_byte == CH_QUOTE) begin
          r_info[n[1:0]] = mk(RK_TOKEN, TT_STRING, 8'd0, ERR_NONE);
          n = n + 3'd1;
          mode_next = S_IDLE;
        end else if (char_byte == CH_BSLASH) begin
          mode_next = S_ESC;
        end else begin
          r_info[n[1:0]] = mk(RK_VALUE, TT_STRING, char_byte, ERR_NONE);
          n = n + 3'd1;
        end
      end
      S_ESC: begin
        r_info[n[1:0]] = mk(RK_VALUE, TT_STRING,
                            (char_byte == CH_LOW_N) ? CH_LF :
                            ((char_byte == CH_LOW_T) ? CH_TAB : char_byte), ERR_NONE);
        n = n + 3'd1;
        mode_next = S_STR;
      end
      S_LT, S_GT: begin
        mode_next = S_IDLE;
        if (char_byte == CH_EQ) begin
          r_info[n[1:0]] = mk(RK_TOKEN, (mode == S_LT) ? TT_LE : TT_GE, 8'd0, ERR_NONE);
          n = n + 3'd1;
        end else begin
          r_info[n[1:0]] = mk(RK_TOKEN, (mode == S_LT) ? TT_LT : TT_GT, 8'd0, ERR_NONE);
          n = n + 3'd1;
          do_idle = 1'b1;
        end
      end
      S_BANG: begin
        if (char_byte == CH_EQ) begin
          r_info[n[1:0]] = mk(RK_TOKEN, TT_NE, 8'd0, ERR_NONE);
          mode_next = S_IDLE;
        end else begin
          r_info[n[1:0]] = mk(RK_ERROR, TT_IDENT, 8'd0, ERR_CHAR);
          mode_next = S_ERROR;
        end
        n = n + 3'd1;
      end
      S_DASH: begin
        if (char_byte == CH_DASH) begin
          mode_next = S_COMMENT;
        end else begin
          r_info[n[1:0]] = mk(RK_ERROR, TT_IDENT, 8'd0, ERR_CHAR);
          n = n + 3'd1;
          mode_next = S_ERROR;
        end
      end
      S_COMMENT: begin
        if (char_byte == CH_LF) mode_next = S_IDLE;
      end
      S_ERROR: ;
      default: do_idle = 1'b1;
    endcase

    // start of a new token at this byte
    if (do_idle) begin
      token_line_next = line_count;
      token_col_next  = col_count;
      mode_next       = id_mode;
      fresh           = id_num || id_ident;
      if (id_num) seen_dot_next = 1'b0;
      if (id_ident) begin
        wbuf_next[0] = upper;
        wlen_next    = LW'(1);
      end
      if (id_emit) begin
        r_info[n[1:0]] = id_res;
        r_line[n[1:0]] = line_count;
        r_col[n[1:0]]  = col_count;
        n = n + 3'd1;
      end
    end

    // word length including this byte, for the keyword match at the flush
    wlen_tok = wlen_next;

    // position of the next byte, saturating
    if (char_byte == CH_LF) begin
      if (line_count < POS_MAX) line_count_next = line_count + 1'b1;
      col_count_next = POSITION_WIDTH'(1);
    end else if (col_count < POS_MAX) begin
      col_count_next = col_count + 1'b1;
    end

    // end of source: flush the pending token, then the end token
    if (end_of_source) begin
      case (mode_next)
        S_NUM, S_IDENT: begin
          ft = (mode_next == S_NUM) ? (seen_dot_next ? TT_FLOAT : TT_INT) : type_nxt;
          if (fresh) begin
            n  = n - 3'd1;
            fv = r_info[n[1:0]].val;
          end
          r_info[n[1:0]] = mk(RK_TOKEN, ft, fv, ERR_NONE);
          r_line[n[1:0]] = token_line_next;
          r_col[n[1:0]]  = token_col_next;
          n = n + 3'd1;
        end
        S_STR, S_ESC, S_BANG, S_DASH: begin
          r_info[n[1:0]] = mk(RK_ERROR, TT_IDENT, 8'd0,
                              (mode_next == S_STR || mode_next == S_ESC) ?
                              ERR_UNCLOSED : ERR_CHAR);
          r_line[n[1:0]] = token_line_next;
          r_col[n[1:0]]  = token_col_next;
          n = n + 3'd1;
          err_end = 1'b1;
        end
        S_LT, S_GT: begin
          r_info[n[1:0]] = mk(RK_TOKEN, (mode_next == S_LT) ? TT_LT : TT_GT, 8'd0, ERR_NONE);
          r_line[n[1:0]] = token_line_next;
          r_col[n[1:0]]  = token_col_next;
          n = n + 3'd1;
        end
        S_ERROR: err_end = 1'b1;
        default: ;
      endcase
      if (!err_end && n < 3'd4) begin
        r_info[n[1:0]] = mk(RK_TOKEN, TT_END, 8'd0, ERR_NONE);
        r_line[n[1:0]] = line_count_next;
        r_col[n[1:0]]  = col_count_next;
        n = n + 3'd1;
      end
      mode_next       = S_IDLE;
      line_count_next = POSITION_WIDTH'(1);
      col_count_next  = POSITION_WIDTH'(1);
      token_line_next = POSITION_WIDTH'(1);
      token_col_next  = POSITION_WIDTH'(1);
      wlen_next       = '0;
      seen_dot_next   = 1'b0;
    end

    if (n > 3'd3) n = 3'd3;
    if (n != 3'd0) r_info[n[1:0] - 2'd1].last = 1'b1;
  end

  // results towards the queue
  always_comb begin
    push_cnt = accept ? n[1:0] : 2'd0;
    for (int k = 0; k < 3; k++) begin
      info[k] = r_info[k];
      line[k] = r_line[k];
      col[k]  = r_col[k];
    end
  end

  assign scan_mode = mode;

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= S_IDLE;
      line_count <= POSITION_WIDTH'(1);
      col_count  <= POSITION_WIDTH'(1);
      token_line <= POSITION_WIDTH'(1);
      token_col  <= POSITION_WIDTH'(1);
      wlen       <= '0;
      seen_dot   <= 1'b0;
    end else if (accept) begin
      mode       <= mode_next;
      line_count <= line_count_next;
      col_count  <= col_count_next;
      token_line <= token_line_next;
      token_col  <= token_col_next;
      wlen       <= wlen_next;
      seen_dot   <= seen_dot_next;
    end
  end

  // word buffer, no reset
  always_ff @(posedge clk) begin
    if (accept) wbuf <= wbuf_next;
  end

endmodule

// ===== rtl/sts_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_queue
// Result queue: up to three results in a cycle, one out a cycle when ready.
// ----------------------------------------------------------------------------
module sts_queue #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [1:0]                push_cnt,
  input  sts_pkg::res_info_t        info [3],
  input  logic [POSITION_WIDTH-1:0] line [3],
  input  logic [POSITION_WIDTH-1:0] col [3],
  output logic                      room,
  output logic [$clog2(sts_pkg::Q_DEPTH+1)-1:0] fill,
  sts_token_if.source               tokens
);
  import sts_pkg::*;

  localparam int QW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  res_info_t                 q_info [Q_DEPTH];
  logic [POSITION_WIDTH-1:0] q_line [Q_DEPTH];
  logic [POSITION_WIDTH-1:0] q_col [Q_DEPTH];
  logic [QW-1:0]             head, tail;
  logic [CW-1:0]             count;
  logic                      pop;

  assign pop  = tokens.valid && tokens.ready;
  assign room = (count <= CW'(Q_DEPTH - 3));
  assign fill = count;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + QW'(push_cnt);
      if (pop) head <= head + QW'(1);
      count <= count + CW'(push_cnt) - CW'(pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push_cnt) begin
        q_info[tail + QW'(k)] <= info[k];
        q_line[tail + QW'(k)] <= line[k];
        q_col[tail + QW'(k)]  <= col[k];
      end
    end
  end

  // head entry to the port
  always_comb begin
    tokens.valid       = (count != '0);
    tokens.result_kind = q_info[head].kind;
    tokens.token_type  = q_info[head].ttype;
    tokens.value_byte  = q_info[head].val;
    tokens.error_code  = q_info[head].err;
    tokens.last_of_run = q_info[head].last;
    tokens.start_line  = q_line[head];
    tokens.start_col   = q_col[head];
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SQL token scanner. Source bytes are streamed
// with random gaps and end-of-source marks. A behavioural scanner written
// here predicts every result. Each result taken from the token port is
// compared field by field, oldest prediction first.
// ----------------------------------------------------------------------------
module tb_top;
  import sts_pkg::*;

  typedef struct {
    logic [7:0] ch;
    logic       eos;
    int         gap;
    bit         drain;
  } src_byte_t;

  typedef struct {
    logic [1:0]  kind;
    logic [6:0]  ttype;
    logic [7:0]  val;
    logic [15:0] line;
    logic [15:0] col;
    logic [1:0]  err;
    logic        last;
  } token_res_t;

  localparam logic [15:0] POS_TOP = 16'hFFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sts_text_if       text_ch ();
  sts_token_if #(16) tok_ch ();

  sql_token_scanner dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .tokens (tok_ch)
  );

  always #2 clk = ~clk;

  src_byte_t  pend_bytes[$];
  token_res_t token_exp[$];
  int         mismatches = 0;
  int         res_seen   = 0;
  bit         gap_on     = 1'b1;
  byte        src_q[$];

  // keyword table, in token order
  string kw_txt[57] = '{
    "SELECT","FROM","WHERE","INSERT","INTO","VALUES","UPDATE","SET","DELETE",
    "CREATE","DROP","TABLE","DATABASE","USE","INT","INTEGER","FLOAT","BOOL",
    "BOOLEAN","TEXT","VARCHAR","AND","OR","NOT","TRUE","FALSE","NULL","ORDER",
    "BY","ASC","DESC","LIMIT","OFFSET","GROUP","HAVING","COUNT","SUM","AVG",
    "MIN","MAX","JOIN","INNER","ON","USER","PASSWORD","WITH","ROLE","GRANT",
    "REVOKE","TO","ALL","SHOW","USERS","AUTH","READONLY","READWRITE","ADMIN"};

  // ---------------------------------------------------------------- scanner
  mode_t       scan_st;
  logic [15:0] cur_line, cur_col, tok_line, tok_col;
  logic [7:0]  word_buf[9];
  int          word_len;
  bit          has_dot;
  token_res_t  step_res[4];
  int          step_n;

  function automatic logic [6:0] kw_code(int k);
    if (k <= 14) return 7'(k + 16);
    if (k == 15) return 7'd30;
    if (k == 16) return 7'd31;
    if (k <= 18) return 7'd32;
    return 7'(k + 14);
  endfunction

  function automatic logic [6:0] word_code();
    bit hit;
    if (word_len > 9) return TT_IDENT;
    for (int k = 0; k < 57; k++) begin
      hit = (kw_txt[k].len() == word_len);
      for (int i = 0; i < word_len; i++)
        if (hit && kw_txt[k][i] != word_buf[i]) hit = 1'b0;
      if (hit) return kw_code(k);
    end
    return TT_IDENT;
  endfunction

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alp(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  task automatic scanner_reset();
    scan_st  = S_IDLE;
    cur_line = 16'd1;
    cur_col  = 16'd1;
    tok_line = 16'd1;
    tok_col  = 16'd1;
    word_len = 0;
    has_dot  = 1'b0;
  endtask

  task automatic put_res(logic [1:0] k, logic [6:0] t, logic [7:0] v,
                         logic [15:0] l, logic [15:0] c, logic [1:0] e);
    if (step_n < 4) begin
      step_res[step_n] = '{k, t, v, l, c, e, 1'b0};
      step_n++;
    end
  endtask

  task automatic add_letter(logic [7:0] c);
    if (word_len < 9) begin
      word_buf[word_len] = (c >= "a" && c <= "z") ? c - 8'd32 : c;
      word_len++;
    end else begin
      word_len = 10;
    end
  endtask

  task automatic close_word(logic [7:0] v);
    if (scan_st == S_NUM) put_res(RK_TOKEN, has_dot ? TT_FLOAT : TT_INT, v,
                                  tok_line, tok_col, ERR_NONE);
    else put_res(RK_TOKEN, word_code(), v, tok_line, tok_col, ERR_NONE);
    scan_st = S_IDLE;
  endtask

  task automatic start_token(logic [7:0] c, logic [15:0] l, logic [15:0] cc,
                             output bit fresh);
    fresh    = 1'b0;
    tok_line = l;
    tok_col  = cc;
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
    if (is_dig(c)) begin
      scan_st = S_NUM;
      has_dot = 1'b0;
      put_res(RK_VALUE, TT_INT, c, l, cc, ERR_NONE);
      fresh = 1'b1;
    end else if (is_alp(c) || c == "_") begin
      scan_st  = S_IDENT;
      word_len = 0;
      add_letter(c);
      put_res(RK_VALUE, TT_IDENT, c, l, cc, ERR_NONE);
      fresh = 1'b1;
    end else begin
      case (c)
        "'": scan_st = S_STR;
        "<": scan_st = S_LT;
        ">": scan_st = S_GT;
        "!": scan_st = S_BANG;
        "-": scan_st = S_DASH;
        "=": put_res(RK_TOKEN, TT_EQ, 8'd0, l, cc, ERR_NONE);
        "(": put_res(RK_TOKEN, TT_LPAREN, 8'd0, l, cc, ERR_NONE);
        ")": put_res(RK_TOKEN, TT_RPAREN, 8'd0, l, cc, ERR_NONE);
        ",": put_res(RK_TOKEN, TT_COMMA, 8'd0, l, cc, ERR_NONE);
        ";": put_res(RK_TOKEN, TT_SEMI, 8'd0, l, cc, ERR_NONE);
        "*": put_res(RK_TOKEN, TT_STAR, 8'd0, l, cc, ERR_NONE);
        default: begin
          put_res(RK_ERROR, TT_IDENT, 8'd0, l, cc, ERR_CHAR);
          scan_st = S_ERROR;
        end
      endcase
    end
  endtask

  // predicts the results of one accepted source byte
  task automatic scan_byte(logic [7:0] c, logic eos);
    logic [15:0] l, cc;
    logic [6:0]  base;
    logic [7:0]  v;
    bit          fresh, err;
    l      = cur_line;
    cc     = cur_col;
    fresh  = 1'b0;
    err    = 1'b0;
    step_n = 0;
    case (scan_st)
      S_NUM: begin
        if (is_dig(c)) put_res(RK_VALUE, has_dot ? TT_FLOAT : TT_INT, c,
                               tok_line, tok_col, ERR_NONE);
        else if (c == "." && !has_dot) begin
          has_dot = 1'b1;
          put_res(RK_VALUE, TT_FLOAT, c, tok_line, tok_col, ERR_NONE);
        end else begin
          close_word(8'd0);
          start_token(c, l, cc, fresh);
        end
      end
      S_IDENT: begin
        if (is_alp(c) || is_dig(c) || c == "_") begin
          add_letter(c);
          put_res(RK_VALUE, TT_IDENT, c, tok_line, tok_col, ERR_NONE);
        end else begin
          close_word(8'd0);
          start_token(c, l, cc, fresh);
        end
      end
      S_STR: begin
        if (c == "'") begin
          put_res(RK_TOKEN, TT_STRING, 8'd0, tok_line, tok_col, ERR_NONE);
          scan_st = S_IDLE;
        end else if (c == "\\") scan_st = S_ESC;
        else put_res(RK_VALUE, TT_STRING, c, tok_line, tok_col, ERR_NONE);
      end
      S_ESC: begin
        v = (c == "n") ? 8'd10 : ((c == "t") ? 8'd9 : c);
        put_res(RK_VALUE, TT_STRING, v, tok_line, tok_col, ERR_NONE);
        scan_st = S_STR;
      end
      S_LT, S_GT: begin
        base    = (scan_st == S_LT) ? TT_LT : TT_GT;
        scan_st = S_IDLE;
        if (c == "=") put_res(RK_TOKEN, base + 7'd1, 8'd0, tok_line, tok_col, ERR_NONE);
        else begin
          put_res(RK_TOKEN, base, 8'd0, tok_line, tok_col, ERR_NONE);
          start_token(c, l, cc, fresh);
        end
      end
      S_BANG: begin
        if (c == "=") begin
          put_res(RK_TOKEN, TT_NE, 8'd0, tok_line, tok_col, ERR_NONE);
          scan_st = S_IDLE;
        end else begin
          put_res(RK_ERROR, TT_IDENT, 8'd0, tok_line, tok_col, ERR_CHAR);
          scan_st = S_ERROR;
        end
      end
      S_DASH: begin
        if (c == "-") scan_st = S_COMMENT;
        else begin
          put_res(RK_ERROR, TT_IDENT, 8'd0, tok_line, tok_col, ERR_CHAR);
          scan_st = S_ERROR;
        end
      end
      S_COMMENT: if (c == 8'd10) scan_st = S_IDLE;
      S_ERROR: ;
      default: start_token(c, l, cc, fresh);
    endcase

    // position of the next byte, saturating
    if (c == 8'd10) begin
      if (cur_line < POS_TOP) cur_line++;
      cur_col = 16'd1;
    end else if (cur_col < POS_TOP) cur_col++;

    // end of source: flush the pending token, then the end token
    if (eos) begin
      case (scan_st)
        S_NUM, S_IDENT: begin
          if (fresh && step_n > 0 && step_res[step_n-1].kind == RK_VALUE) begin
            v = step_res[step_n-1].val;
            step_n--;
            close_word(v);
          end else close_word(8'd0);
        end
        S_STR, S_ESC: begin
          put_res(RK_ERROR, TT_IDENT, 8'd0, tok_line, tok_col, ERR_UNCLOSED);
          err = 1'b1;
        end
        S_LT: put_res(RK_TOKEN, TT_LT, 8'd0, tok_line, tok_col, ERR_NONE);
        S_GT: put_res(RK_TOKEN, TT_GT, 8'd0, tok_line, tok_col, ERR_NONE);
        S_BANG, S_DASH: begin
          put_res(RK_ERROR, TT_IDENT, 8'd0, tok_line, tok_col, ERR_CHAR);
          err = 1'b1;
        end
        S_ERROR: err = 1'b1;
        default: ;
      endcase
      if (!err) put_res(RK_TOKEN, TT_END, 8'd0, cur_line, cur_col, ERR_NONE);
      scanner_reset();
    end

    if (step_n > 3) step_n = 3;
    for (int k = 0; k < step_n; k++) begin
      step_res[k].last = (k == step_n - 1);
      token_exp.insert(token_exp.size(), step_res[k]);
    end
  endtask

  // ------------------------------------------------------------ stimulus
  task automatic src_put(int c);
    src_q.insert(src_q.size(), 8'(c));
  endtask

  task automatic queue_src(bit drain_first = 1'b0);
    src_byte_t b;
    foreach (src_q[i]) begin
      b.ch    = src_q[i];
      b.eos   = (i == src_q.size() - 1);
      b.gap   = gap_on ? $urandom_range(0, 12) : 0;
      b.drain = drain_first && i == 0;
      pend_bytes.insert(pend_bytes.size(), b);
    end
    src_q.delete();
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) src_put(s[i]);
  endtask

  task automatic add_rand_token();
    string ops[11] = '{"=", "!=", "<", "<=", ">", ">=", "(", ")", ",", ";", "*"};
    string w;
    int    n;
    case ($urandom_range(0, 9))
      0, 1: begin
        w = kw_txt[$urandom_range(0, 56)];
        for (int i = 0; i < w.len(); i++)
          src_put($urandom_range(0, 1) ? w[i] + 8'd32 : w[i]);
      end
      2: begin
        src_put($urandom_range(0, 3) == 0 ? "_" : "a" + $urandom_range(0, 25));
        n = $urandom_range(0, 11);
        repeat (n) case ($urandom_range(0, 3))
          0: src_put("0" + $urandom_range(0, 9));
          1: src_put("_");
          2: src_put("A" + $urandom_range(0, 25));
          default: src_put("a" + $urandom_range(0, 25));
        endcase
      end
      3: begin
        repeat ($urandom_range(1, 4)) src_put("0" + $urandom_range(0, 9));
        if ($urandom_range(0, 1)) begin
          src_put(".");
          repeat ($urandom_range(0, 3)) src_put("0" + $urandom_range(0, 9));
        end
      end
      4: begin
        src_put("'");
        repeat ($urandom_range(0, 5)) case ($urandom_range(0, 4))
          0: begin src_put("\\"); src_put($urandom_range(0, 255)); end
          1: src_put($urandom_range(128, 255));
          default: src_put("a" + $urandom_range(0, 25));
        endcase
        src_put("'");
      end
      5, 6: add_text(ops[$urandom_range(0, 10)]);
      7: begin
        add_text("--");
        repeat ($urandom_range(0, 4)) src_put($urandom_range(32, 255));
        src_put(10);
      end
      8: src_put($urandom_range(0, 255));
      default: src_put(" ");
    endcase
    case ($urandom_range(0, 5))
      0: src_put(10);
      1: src_put(9);
      2, 3: src_put(" ");
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------- text driver
  bit taken = 1'b0;
  int gap_left = 0;

  initial begin
    text_ch.valid         = 1'b0;
    text_ch.char_byte     = 8'd0;
    text_ch.end_of_source = 1'b0;
    tok_ch.ready          = 1'b0;
  end

  // request accepted: predict its results
  always @(posedge clk) begin
    if (!rst && text_ch.valid && text_ch.ready) begin
      taken = 1'b1;
      scan_byte(text_ch.char_byte, text_ch.end_of_source);
    end
  end

  always @(negedge clk) begin
    src_byte_t b;
    logic      nv;
    nv = text_ch.valid;
    if (rst) nv = 1'b0;
    else if (!text_ch.valid || taken) begin
      nv = 1'b0;
      if (gap_left > 0) gap_left--;
      else if (pend_bytes.size() > 0 && (!pend_bytes[0].drain || token_exp.size() == 0)) begin
        b = pend_bytes.pop_front();
        text_ch.char_byte     <= b.ch;
        text_ch.end_of_source <= b.eos;
        nv = 1'b1;
        gap_left = (pend_bytes.size() > 0) ? pend_bytes[0].gap : 0;
      end
    end
    taken = 1'b0;
    text_ch.valid <= nv;
  end

  // -------------------------------------------------------- token monitor
  bit got        = 1'b0;
  int sink_gap   = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  always @(posedge clk) begin
    token_res_t e;
    if (!rst && tok_ch.valid && tok_ch.ready) begin
      got = 1'b1;
      res_seen++;
      if (token_exp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind %0d type %0d val %02h",
                   tok_ch.result_kind, tok_ch.token_type, tok_ch.value_byte);
      end else begin
        e = token_exp.pop_front();
        if (tok_ch.result_kind !== e.kind || tok_ch.token_type !== e.ttype ||
            tok_ch.value_byte !== e.val || tok_ch.start_line !== e.line ||
            tok_ch.start_col !== e.col || tok_ch.error_code !== e.err ||
            tok_ch.last_of_run !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp k%0d t%0d v%02h %0d:%0d e%0d l%0d got k%0d t%0d v%02h %0d:%0d e%0d l%0d",
                     e.kind, e.ttype, e.val, e.line, e.col, e.err, e.last,
                     tok_ch.result_kind, tok_ch.token_type, tok_ch.value_byte,
                     tok_ch.start_line, tok_ch.start_col, tok_ch.error_code,
                     tok_ch.last_of_run);
        end
      end
    end
  end

  // one long hold-off of the result port
  always @(posedge clk) begin
    if (!hold_done && res_seen >= 60) begin
      hold_done = 1'b1;
      hold_left = 300;
    end else if (hold_left > 0) hold_left--;
  end

  always @(negedge clk) begin
    logic nr;
    nr = tok_ch.ready;
    if (rst || hold_left > 0) nr = 1'b0;
    else begin
      if (got) sink_gap = gap_on ? $urandom_range(0, 12) : 0;
      if (got || !tok_ch.ready) begin
        if (sink_gap > 0) begin
          sink_gap--;
          nr = 1'b0;
        end else nr = 1'b1;
      end
    end
    got = 1'b0;
    tok_ch.ready <= nr;
  end

  // --------------------------------------------------------------- limit
  initial begin
    #20000000;
    $display("** sql_token_scanner: FAILED **");
    $finish;
  end

  // ----------------------------------------------------------------- main
  initial begin
    int nbytes;
    scanner_reset();
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // directed sources
    add_text("SELECT a_1, 12.5 FROM t WHERE x<=3 AND y>=4 OR z!=5;"); queue_src();
    add_text("sElect * from Users where n='a\\nb\\tc\\q\\'' -- note\n(1<2)>(3)=");
    queue_src();
    add_text("1.2.3 x"); queue_src();
    add_text("!x"); queue_src();
    add_text("-x"); queue_src();
    add_text("'abc"); queue_src();
    add_text("'ab\\"); queue_src();
    add_text("readwrite READWRITEX integer boolean"); queue_src();
    add_text("7"); queue_src();
    add_text("a 7"); queue_src();
    add_text("q<"); queue_src();
    add_text("x>"); queue_src();
    add_text("x!"); queue_src();
    add_text("--c"); queue_src();
    add_text("a\t\v\f\r b "); queue_src();
    src_put(8'hFF); src_put(8'h41); queue_src();
    src_put(8'h80); queue_src();
    src_put(8'h00); queue_src();

    // random sources, with bursts and idling stretches
    nbytes = 0;
    for (int s = 0; nbytes < 16; s++) begin
      gap_on = (s % 4) != 3;
      repeat ($urandom_range(3, 10)) add_rand_token();
      if (src_q.size() == 0) src_put("x");
      nbytes += src_q.size();
      queue_src(s == 0);
    end

    wait (pend_bytes.size() == 0 && !text_ch.valid);
    wait (token_exp.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && token_exp.size() == 0)
      $display("** sql_token_scanner: PASSED **");
    else
      $display("** sql_token_scanner: FAILED **");
    $finish;
  end

endmodule
